/* sv/bba_pkg.sv */
package bba_pkg;

  // Bitmap word geometry: the map is stored as words of 32 block bits.
  localparam int WORD_BITS  = 32;
  localparam int WORD_IDX_W = 5;

  // Field widths of the items.
  localparam int BLOCK_W  = 12;
  localparam int TRACK_W  = 9;
  localparam int SECTOR_W = 4;
  localparam int FTRACK_W = 8;

  // Request codes.
  localparam logic [1:0] ACT_TEST      = 2'd0;
  localparam logic [1:0] ACT_MARK_USED = 2'd1;
  localparam logic [1:0] ACT_MARK_FREE = 2'd2;
  localparam logic [1:0] ACT_FIND_FREE = 2'd3;

  // Blocks 0 to 2 are in use after reset; they all sit in word 0.
  localparam logic [WORD_BITS-1:0] RESET_USED_MASK = 32'h0000_0007;

  // Find never returns blocks 0 and 1.
  localparam logic [WORD_BITS-1:0] LOW_BLOCK_MASK = 32'hFFFF_FFFC;

  // Floppy geometry: 18 sectors per track, two heads of 9 sectors.
  localparam int SECTORS_PER_TRACK = 18;
  localparam int SECTORS_PER_HEAD  = 9;

  // Division by 18 as a multiply by ceil(2^17 / 18); exact for 12-bit blocks.
  localparam int                RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_18   = 13'd7282;
  localparam int                RECIP_SHIFT = 17;
  localparam int                PROD_W      = BLOCK_W + RECIP_W;
  localparam int                QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam int                REM_W       = 5;

  typedef struct packed {
    logic [1:0]         action;
    logic [BLOCK_W-1:0] block_index;
  } alloc_req_t;

  typedef struct packed {
    logic                flag;
    logic [BLOCK_W-1:0]  free_block;
    logic                head;
    logic [TRACK_W-1:0]  track;
    logic [SECTOR_W-1:0] sector;
  } alloc_rsp_t;

  // Lowest set bit of a word: {hit, position}.
  function automatic logic [WORD_IDX_W:0] first_one(input logic [WORD_BITS-1:0] v);
    logic                  hit;
    logic [WORD_IDX_W-1:0] pos;
    hit = 1'b0;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        hit = 1'b1;
        pos = WORD_IDX_W'(i);
      end
    end
    return {hit, pos};
  endfunction

endpackage

/* sv/bba_bitmap.sv */
module bba_bitmap #(
  parameter int WORDS = 64,
  parameter int AW    = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [AW-1:0]                  rd_addr_i,
  input  logic                           wr_en_i,
  input  logic [AW-1:0]                  wr_addr_i,
  input  logic [bba_pkg::WORD_BITS-1:0]  wr_data_i,
  output logic [bba_pkg::WORD_BITS-1:0]  rd_word_o
);

  logic [bba_pkg::WORD_BITS-1:0] mem_q [WORDS];
  logic [WORDS-1:0]              row_valid_q;
  logic [bba_pkg::WORD_BITS-1:0] rd_data_q;
  logic                          rd_valid_q;
  logic                          rd_zero_q;

  // Word storage with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  // One valid bit per row; a row never written reads as its reset contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      rd_zero_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= row_valid_q[rd_addr_i];
      rd_zero_q  <= (rd_addr_i == '0);
    end
  end

  // Select stored data or the reset pattern of the row read.
  always_comb begin
    if (rd_valid_q) begin
      rd_word_o = rd_data_q;
    end else if (rd_zero_q) begin
      rd_word_o = bba_pkg::RESET_USED_MASK;
    end else begin
      rd_word_o = '0;
    end
  end

endmodule

/* sv/bba_geometry.sv */
module bba_geometry (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic [bba_pkg::BLOCK_W-1:0]   block_i,
  input  logic [bba_pkg::FTRACK_W-1:0]  first_track_i,
  output logic                          head_o,
  output logic [bba_pkg::TRACK_W-1:0]   track_o,
  output logic [bba_pkg::SECTOR_W-1:0]  sector_o
);

  logic [bba_pkg::BLOCK_W-1:0]  block_q;
  logic [bba_pkg::PROD_W-1:0]   prod_q;
  logic [bba_pkg::QUOT_W-1:0]   quot;
  logic [bba_pkg::BLOCK_W-1:0]  quot_x18;
  logic [bba_pkg::REM_W-1:0]    rem;

  // Reciprocal multiply for the division by 18, registered.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      block_q <= block_i;
      prod_q  <= bba_pkg::PROD_W'(block_i) * bba_pkg::PROD_W'(bba_pkg::RECIP_18);
    end
  end

  // Quotient, remainder and the split of the remainder over the two heads.
  always_comb begin
    quot     = prod_q[bba_pkg::PROD_W-1:bba_pkg::RECIP_SHIFT];
    quot_x18 = (bba_pkg::BLOCK_W'(quot) << 4) + (bba_pkg::BLOCK_W'(quot) << 1);
    rem      = bba_pkg::REM_W'(block_q - quot_x18);
    head_o   = (rem >= bba_pkg::REM_W'(bba_pkg::SECTORS_PER_HEAD));
    if (head_o) begin
      sector_o = bba_pkg::SECTOR_W'(rem - bba_pkg::REM_W'(bba_pkg::SECTORS_PER_HEAD - 1));
    end else begin
      sector_o = bba_pkg::SECTOR_W'(rem + 5'd1);
    end
    track_o = bba_pkg::TRACK_W'(quot) + bba_pkg::TRACK_W'(first_track_i);
  end

endmodule

/* sv/block_bitmap_allocator_unit.sv */
// Free-block bitmap allocator. The map holds one used bit per block, stored as
// 32-bit words in an internal memory with one read and one write port; blocks
// 0 to 2 are used after reset, without any clearing pass. One item is handled
// at a time and in_stall_o stays high while it is in work. Test, mark-used
// and mark-free go through a word read, an evaluate and write step and a
// geometry step before the next item can be accepted; an index at or beyond
// NUM_BLOCKS skips the word read and evaluation. Find-free walks the map one
// word per cycle from word 0 until a word holds a free block or the last word
// has been read. Head, track and sector come from a registered reciprocal
// multiply for the division by 18. A finished result waits in the output
// register without holding up the next item's work until its own result is
// ready.
module block_bitmap_allocator_unit #(
  parameter int NUM_BLOCKS = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bba_pkg::FTRACK_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bba_pkg::alloc_req_t           in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bba_pkg::alloc_rsp_t           out_item_o
);

  localparam int WORDS = (NUM_BLOCKS + bba_pkg::WORD_BITS - 1) / bba_pkg::WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [bba_pkg::WORD_BITS-1:0] LAST_MASK =
    {bba_pkg::WORD_BITS{1'b1}} >> (bba_pkg::WORD_BITS * WORDS - NUM_BLOCKS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_GEO  = 2'd2;

  logic [1:0]                        state_q, state_d;
  logic [1:0]                        action_q;
  logic [bba_pkg::BLOCK_W-1:0]       index_q;
  logic [AW-1:0]                     word_q, word_d;
  logic                              flag_q, flag_d;
  logic [bba_pkg::BLOCK_W-1:0]       found_q, found_d;
  logic [bba_pkg::FTRACK_W-1:0]      first_track_q;
  logic                              out_valid_q;
  bba_pkg::alloc_rsp_t               out_q;

  logic                              in_take;
  logic                              out_load;
  logic [bba_pkg::WORD_BITS-1:0]     rd_word;
  logic [bba_pkg::WORD_BITS-1:0]     bit_mask;
  logic                              cur_bit;
  logic [bba_pkg::WORD_BITS-1:0]     avail;
  logic [bba_pkg::WORD_IDX_W:0]      find_res;
  logic                              wr_en;
  logic [bba_pkg::WORD_BITS-1:0]     wr_data;
  logic                              geo_load;
  logic [bba_pkg::BLOCK_W-1:0]       geo_block;
  logic                              geo_head;
  logic [bba_pkg::TRACK_W-1:0]       geo_track;
  logic [bba_pkg::SECTOR_W-1:0]      geo_sector;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == ST_GEO) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_track_q <= '0;
    end else if (cfg_we_i) begin
      first_track_q <= cfg_wdata_i;
    end
  end

  // Bitmap storage.
  bba_bitmap #(
    .WORDS(WORDS),
    .AW   (AW)
  ) u_bitmap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_addr_i(word_d),
    .wr_en_i  (wr_en),
    .wr_addr_i(word_q),
    .wr_data_i(wr_data),
    .rd_word_o(rd_word)
  );

  // Geometry of the block concerned.
  bba_geometry u_geometry (
    .clk_i        (clk_i),
    .load_i       (geo_load),
    .block_i      (geo_block),
    .first_track_i(first_track_q),
    .head_o       (geo_head),
    .track_o      (geo_track),
    .sector_o     (geo_sector)
  );

  // Bit of the addressed block and free candidates of the current word.
  always_comb begin
    bit_mask = bba_pkg::WORD_BITS'(1) << index_q[bba_pkg::WORD_IDX_W-1:0];
    cur_bit  = rd_word[index_q[bba_pkg::WORD_IDX_W-1:0]];
    avail    = ~rd_word;
    if (word_q == LAST_WORD) begin
      avail = avail & LAST_MASK;
    end
    if (word_q == '0) begin
      avail = avail & bba_pkg::LOW_BLOCK_MASK;
    end
    find_res = bba_pkg::first_one(avail);
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    word_d    = word_q;
    flag_d    = flag_q;
    found_d   = found_q;
    wr_en     = 1'b0;
    wr_data   = rd_word;
    geo_load  = 1'b0;
    geo_block = index_q;
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          flag_d  = 1'b0;
          found_d = '0;
          if (in_item_i.action == bba_pkg::ACT_FIND_FREE) begin
            word_d  = '0;
            state_d = ST_EVAL;
          end else if ({1'b0, in_item_i.block_index} <
                       (bba_pkg::BLOCK_W + 1)'(NUM_BLOCKS)) begin
            word_d  = in_item_i.block_index[bba_pkg::WORD_IDX_W +: AW];
            state_d = ST_EVAL;
          end else begin
            geo_load  = 1'b1;
            geo_block = in_item_i.block_index;
            state_d   = ST_GEO;
          end
        end
      end
      ST_EVAL: begin
        case (action_q)
          bba_pkg::ACT_TEST: begin
            flag_d   = cur_bit;
            geo_load = 1'b1;
            state_d  = ST_GEO;
          end
          bba_pkg::ACT_MARK_USED: begin
            flag_d   = !cur_bit;
            wr_en    = !cur_bit;
            wr_data  = rd_word | bit_mask;
            geo_load = 1'b1;
            state_d  = ST_GEO;
          end
          bba_pkg::ACT_MARK_FREE: begin
            flag_d   = cur_bit;
            wr_en    = cur_bit;
            wr_data  = rd_word & ~bit_mask;
            geo_load = 1'b1;
            state_d  = ST_GEO;
          end
          default: begin
            if (find_res[bba_pkg::WORD_IDX_W]) begin
              flag_d    = 1'b1;
              found_d   = bba_pkg::BLOCK_W'({word_q, find_res[bba_pkg::WORD_IDX_W-1:0]});
              geo_load  = 1'b1;
              geo_block = found_d;
              state_d   = ST_GEO;
            end else if (word_q == LAST_WORD) begin
              flag_d    = 1'b0;
              found_d   = '0;
              geo_load  = 1'b1;
              geo_block = '0;
              state_d   = ST_GEO;
            end else begin
              word_d = word_q + 1'b1;
            end
          end
        endcase
      end
      ST_GEO: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      word_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      word_q  <= word_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q <= in_item_i.action;
      index_q  <= in_item_i.block_index;
    end
    flag_q  <= flag_d;
    found_q <= found_d;
    if (out_load) begin
      out_q.flag       <= flag_q;
      out_q.free_block <= found_q;
      out_q.head       <= geo_head;
      out_q.track      <= geo_track;
      out_q.sector     <= geo_sector;
    end
  end

  // The bitmap is written only while an item is being evaluated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_EVAL))
    else $error("bitmap write outside evaluation");

  // An accepted item raises in_stall_o, holding off the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_stall_o)
    else $error("item accepted while previous one still in work");

  // A loaded result shows up as valid in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("loaded result not presented");

  // A reported free block is never one of the two reserved blocks and is flagged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.free_block != '0)) |->
      (out_item_o.flag && (out_item_o.free_block >= bba_pkg::BLOCK_W'(2))))
    else $error("free block result out of range");

  // The output register only changes when it is empty or being drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule
